FILE: src/hff_pkg.sv
// Shared types, operation codes, register-file map and the sequencer program
// of the HLLE face flux block. No dependencies.
package hff_pkg;

  typedef struct packed {
    logic        func;
    logic [63:0] density_left;
    logic [63:0] density_right;
    logic [63:0] momentum_left;
    logic [63:0] momentum_right;
    logic [63:0] energy_left;
    logic [63:0] energy_right;
    logic [63:0] pressure_left;
    logic [63:0] pressure_right;
    logic [62:0] sound_left;
    logic [62:0] sound_right;
  } in_item_t;

  typedef struct packed {
    logic [63:0] flux_mass;
    logic [63:0] flux_normal_momentum;
    logic [63:0] flux_energy;
    logic [63:0] flux_passive;
    logic        degenerate;
  } out_item_t;

  localparam logic FUNC_FACE    = 1'b0;
  localparam logic FUNC_PASSIVE = 1'b1;

  localparam int NWORDS   = 10;
  localparam int RF_DEPTH = 32;
  localparam int RF_AW    = 5;
  localparam int PC_W     = 7;

  // operation codes
  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_DIV   = 4'd3;
  localparam logic [3:0] OP_SQRT  = 4'd4;
  localparam logic [3:0] OP_HALVE = 4'd5;
  localparam logic [3:0] OP_MIN   = 4'd6;
  localparam logic [3:0] OP_MAX   = 4'd7;
  localparam logic [3:0] OP_CLPN  = 4'd8;
  localparam logic [3:0] OP_CLPP  = 4'd9;
  localparam logic [3:0] OP_JZ    = 4'd10;
  localparam logic [3:0] OP_END   = 4'd11;

  // result field selects
  localparam logic [2:0] OS_NONE    = 3'd0;
  localparam logic [2:0] OS_MASS    = 3'd1;
  localparam logic [2:0] OS_MOM     = 3'd2;
  localparam logic [2:0] OS_ENERGY  = 3'd3;
  localparam logic [2:0] OS_PASSIVE = 3'd4;

  // register file map; the first ten match the order of the loaded words
  localparam logic [4:0] R_RL   = 5'd0;
  localparam logic [4:0] R_RR   = 5'd1;
  localparam logic [4:0] R_ML   = 5'd2;
  localparam logic [4:0] R_MR   = 5'd3;
  localparam logic [4:0] R_EL   = 5'd4;
  localparam logic [4:0] R_ER   = 5'd5;
  localparam logic [4:0] R_PL   = 5'd6;
  localparam logic [4:0] R_PR   = 5'd7;
  localparam logic [4:0] R_AL   = 5'd8;
  localparam logic [4:0] R_AR   = 5'd9;
  localparam logic [4:0] R_SL   = 5'd10;
  localparam logic [4:0] R_SR   = 5'd11;
  localparam logic [4:0] R_UL   = 5'd12;
  localparam logic [4:0] R_UR   = 5'd13;
  localparam logic [4:0] R_SQL  = 5'd14;
  localparam logic [4:0] R_SQR  = 5'd15;
  localparam logic [4:0] R_DEN  = 5'd16;
  localparam logic [4:0] R_ROEU = 5'd17;
  localparam logic [4:0] R_T1   = 5'd18;
  localparam logic [4:0] R_DU   = 5'd19;
  localparam logic [4:0] R_WW   = 5'd20;
  localparam logic [4:0] R_HA   = 5'd21;
  localparam logic [4:0] R_ROEA = 5'd22;
  localparam logic [4:0] R_DS   = 5'd23;
  localparam logic [4:0] R_SLSR = 5'd24;
  localparam logic [4:0] R_TA   = 5'd25;
  localparam logic [4:0] R_TB   = 5'd26;
  localparam logic [4:0] R_TC   = 5'd27;
  localparam logic [4:0] R_FL   = 5'd28;
  localparam logic [4:0] R_FR   = 5'd29;

  localparam logic [PC_W-1:0] PC_FACE    = 7'd0;
  localparam logic [PC_W-1:0] PC_PASSIVE = 7'd66;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] osel;
    logic [4:0] dst;
    logic [4:0] ra;
    logic [4:0] rb;
  } uop_t;

  typedef struct packed {
    logic       valid;
    logic       func;
  } head_t;

  typedef struct packed {
    logic       start;
    logic [3:0] op;
  } alu_req_t;

  function automatic uop_t mk(input logic [3:0] op, input logic [4:0] dst,
                              input logic [4:0] ra, input logic [4:0] rb,
                              input logic [2:0] osel);
    uop_t u;
    u.op   = op;
    u.osel = osel;
    u.dst  = dst;
    u.ra   = ra;
    u.rb   = rb;
    return u;
  endfunction

  function automatic uop_t rom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // face: velocities and Roe averages
      7'd0:  u = mk(OP_SQRT,  R_SQL,  R_RL,   R_RL,   OS_NONE);
      7'd1:  u = mk(OP_SQRT,  R_SQR,  R_RR,   R_RR,   OS_NONE);
      7'd2:  u = mk(OP_DIV,   R_UL,   R_ML,   R_RL,   OS_NONE);
      7'd3:  u = mk(OP_DIV,   R_UR,   R_MR,   R_RR,   OS_NONE);
      7'd4:  u = mk(OP_ADD,   R_DEN,  R_SQL,  R_SQR,  OS_NONE);
      7'd5:  u = mk(OP_MUL,   R_TA,   R_SQL,  R_UL,   OS_NONE);
      7'd6:  u = mk(OP_MUL,   R_TB,   R_SQR,  R_UR,   OS_NONE);
      7'd7:  u = mk(OP_ADD,   R_TA,   R_TA,   R_TB,   OS_NONE);
      7'd8:  u = mk(OP_DIV,   R_ROEU, R_TA,   R_DEN,  OS_NONE);
      7'd9:  u = mk(OP_MUL,   R_TA,   R_AL,   R_AL,   OS_NONE);
      7'd10: u = mk(OP_MUL,   R_TA,   R_SQL,  R_TA,   OS_NONE);
      7'd11: u = mk(OP_MUL,   R_TB,   R_AR,   R_AR,   OS_NONE);
      7'd12: u = mk(OP_MUL,   R_TB,   R_SQR,  R_TB,   OS_NONE);
      7'd13: u = mk(OP_ADD,   R_TA,   R_TA,   R_TB,   OS_NONE);
      7'd14: u = mk(OP_DIV,   R_T1,   R_TA,   R_DEN,  OS_NONE);
      7'd15: u = mk(OP_SUB,   R_DU,   R_UR,   R_UL,   OS_NONE);
      7'd16: u = mk(OP_MUL,   R_TA,   R_SQL,  R_SQR,  OS_NONE);
      7'd17: u = mk(OP_HALVE, R_TA,   R_TA,   R_TA,   OS_NONE);
      7'd18: u = mk(OP_MUL,   R_TB,   R_DEN,  R_DEN,  OS_NONE);
      7'd19: u = mk(OP_DIV,   R_WW,   R_TA,   R_TB,   OS_NONE);
      7'd20: u = mk(OP_MUL,   R_TA,   R_WW,   R_DU,   OS_NONE);
      7'd21: u = mk(OP_MUL,   R_TA,   R_TA,   R_DU,   OS_NONE);
      7'd22: u = mk(OP_ADD,   R_TA,   R_T1,   R_TA,   OS_NONE);
      7'd23: u = mk(OP_SQRT,  R_ROEA, R_TA,   R_TA,   OS_NONE);
      7'd24: u = mk(OP_HALVE, R_HA,   R_ROEA, R_ROEA, OS_NONE);
      // wave-speed bounds
      7'd25: u = mk(OP_SUB,   R_TA,   R_UL,   R_AL,   OS_NONE);
      7'd26: u = mk(OP_SUB,   R_TB,   R_ROEU, R_HA,   OS_NONE);
      7'd27: u = mk(OP_MIN,   R_SL,   R_TA,   R_TB,   OS_NONE);
      7'd28: u = mk(OP_CLPN,  R_SL,   R_SL,   R_SL,   OS_NONE);
      7'd29: u = mk(OP_ADD,   R_TA,   R_ROEU, R_HA,   OS_NONE);
      7'd30: u = mk(OP_ADD,   R_TB,   R_UR,   R_AR,   OS_NONE);
      7'd31: u = mk(OP_MAX,   R_SR,   R_TA,   R_TB,   OS_NONE);
      7'd32: u = mk(OP_CLPP,  R_SR,   R_SR,   R_SR,   OS_NONE);
      7'd33: u = mk(OP_SUB,   R_DS,   R_SR,   R_SL,   OS_NONE);
      7'd34: u = mk(OP_JZ,    R_DS,   R_DS,   R_DS,   OS_NONE);
      7'd35: u = mk(OP_MUL,   R_SLSR, R_SL,   R_SR,   OS_NONE);
      // mass flux
      7'd36: u = mk(OP_MUL,   R_TA,   R_SR,   R_ML,   OS_NONE);
      7'd37: u = mk(OP_MUL,   R_TB,   R_SL,   R_MR,   OS_NONE);
      7'd38: u = mk(OP_SUB,   R_TA,   R_TA,   R_TB,   OS_NONE);
      7'd39: u = mk(OP_SUB,   R_TC,   R_RR,   R_RL,   OS_NONE);
      7'd40: u = mk(OP_MUL,   R_TB,   R_SLSR, R_TC,   OS_NONE);
      7'd41: u = mk(OP_ADD,   R_TA,   R_TA,   R_TB,   OS_NONE);
      7'd42: u = mk(OP_DIV,   R_TA,   R_TA,   R_DS,   OS_MASS);
      // normal momentum flux
      7'd43: u = mk(OP_MUL,   R_FL,   R_ML,   R_UL,   OS_NONE);
      7'd44: u = mk(OP_ADD,   R_FL,   R_FL,   R_PL,   OS_NONE);
      7'd45: u = mk(OP_MUL,   R_FR,   R_MR,   R_UR,   OS_NONE);
      7'd46: u = mk(OP_ADD,   R_FR,   R_FR,   R_PR,   OS_NONE);
      7'd47: u = mk(OP_MUL,   R_TA,   R_SR,   R_FL,   OS_NONE);
      7'd48: u = mk(OP_MUL,   R_TB,   R_SL,   R_FR,   OS_NONE);
      7'd49: u = mk(OP_SUB,   R_TA,   R_TA,   R_TB,   OS_NONE);
      7'd50: u = mk(OP_SUB,   R_TC,   R_MR,   R_ML,   OS_NONE);
      7'd51: u = mk(OP_MUL,   R_TB,   R_SLSR, R_TC,   OS_NONE);
      7'd52: u = mk(OP_ADD,   R_TA,   R_TA,   R_TB,   OS_NONE);
      7'd53: u = mk(OP_DIV,   R_TA,   R_TA,   R_DS,   OS_MOM);
      // energy flux
      7'd54: u = mk(OP_ADD,   R_FL,   R_EL,   R_PL,   OS_NONE);
      7'd55: u = mk(OP_MUL,   R_FL,   R_UL,   R_FL,   OS_NONE);
      7'd56: u = mk(OP_ADD,   R_FR,   R_ER,   R_PR,   OS_NONE);
      7'd57: u = mk(OP_MUL,   R_FR,   R_UR,   R_FR,   OS_NONE);
      7'd58: u = mk(OP_MUL,   R_TA,   R_SR,   R_FL,   OS_NONE);
      7'd59: u = mk(OP_MUL,   R_TB,   R_SL,   R_FR,   OS_NONE);
      7'd60: u = mk(OP_SUB,   R_TA,   R_TA,   R_TB,   OS_NONE);
      7'd61: u = mk(OP_SUB,   R_TC,   R_ER,   R_EL,   OS_NONE);
      7'd62: u = mk(OP_MUL,   R_TB,   R_SLSR, R_TC,   OS_NONE);
      7'd63: u = mk(OP_ADD,   R_TA,   R_TA,   R_TB,   OS_NONE);
      7'd64: u = mk(OP_DIV,   R_TA,   R_TA,   R_DS,   OS_ENERGY);
      7'd65: u = mk(OP_END,   R_TA,   R_TA,   R_TA,   OS_NONE);
      // passive quantity, advected with the stored bounds and velocities
      7'd66: u = mk(OP_SUB,   R_DS,   R_SR,   R_SL,   OS_NONE);
      7'd67: u = mk(OP_JZ,    R_DS,   R_DS,   R_DS,   OS_NONE);
      7'd68: u = mk(OP_MUL,   R_SLSR, R_SL,   R_SR,   OS_NONE);
      7'd69: u = mk(OP_MUL,   R_FL,   R_UL,   R_RL,   OS_NONE);
      7'd70: u = mk(OP_MUL,   R_FR,   R_UR,   R_RR,   OS_NONE);
      7'd71: u = mk(OP_MUL,   R_TA,   R_SR,   R_FL,   OS_NONE);
      7'd72: u = mk(OP_MUL,   R_TB,   R_SL,   R_FR,   OS_NONE);
      7'd73: u = mk(OP_SUB,   R_TA,   R_TA,   R_TB,   OS_NONE);
      7'd74: u = mk(OP_SUB,   R_TC,   R_RR,   R_RL,   OS_NONE);
      7'd75: u = mk(OP_MUL,   R_TB,   R_SLSR, R_TC,   OS_NONE);
      7'd76: u = mk(OP_ADD,   R_TA,   R_TA,   R_TB,   OS_NONE);
      7'd77: u = mk(OP_DIV,   R_TA,   R_TA,   R_DS,   OS_PASSIVE);
      default: u = mk(OP_END, R_TA,   R_TA,   R_TA,   OS_NONE);
    endcase
    return u;
  endfunction

endpackage

FILE: src/hff_ram.sv
// Generic register-file RAM: one write port, two registered read ports.
// No dependencies.
module hff_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: src/hff_alu.sv
// Shared fixed-point unit: saturating add/sub/min/max, chunked multiplier,
// one-bit-per-cycle divider and square root. Depends on hff_pkg.
module hff_alu #(
  parameter int WORD_BITS = 64,
  parameter int FRAC_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hff_pkg::alu_req_t    req,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  output logic                 done,
  output logic [WORD_BITS-1:0] res
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int NCH = (W + 15) / 16;
  localparam int NB  = NCH * 16;
  localparam int P   = W + NB;
  localparam int Q   = W + F;
  localparam int R   = Q + (Q % 2);
  localparam int H   = R / 2;
  localparam int MX  = P + Q;
  localparam int CW  = $clog2(Q + 1);

  localparam logic [W-1:0]  WMAX    = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  WMIN    = {1'b1, {(W-1){1'b0}}};
  localparam logic [MX-1:0] LIM_POS = MX'({(W-1){1'b1}});

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [W-1:0] sat(input logic neg, input logic [MX-1:0] m);
    logic [W-1:0] r;
    if (neg) begin
      if (m > LIM_POS + 1'b1) r = WMIN;
      else                    r = ~m[W-1:0] + 1'b1;
    end else begin
      if (m > LIM_POS) r = WMAX;
      else             r = m[W-1:0];
    end
    return r;
  endfunction

  function automatic logic [W-1:0] simple(input logic [3:0] op,
                                          input logic [W-1:0] x,
                                          input logic [W-1:0] y);
    logic [W:0]   s;
    logic [W-1:0] m;
    logic [W-1:0] r;
    s = '0;
    m = '0;
    case (op)
      hff_pkg::OP_ADD: begin
        s = {x[W-1], x} + {y[W-1], y};
        r = (s[W] ^ s[W-1]) ? (s[W] ? WMIN : WMAX) : s[W-1:0];
      end
      hff_pkg::OP_SUB: begin
        s = {x[W-1], x} - {y[W-1], y};
        r = (s[W] ^ s[W-1]) ? (s[W] ? WMIN : WMAX) : s[W-1:0];
      end
      hff_pkg::OP_MIN:  r = ($signed(x) < $signed(y)) ? x : y;
      hff_pkg::OP_MAX:  r = ($signed(x) > $signed(y)) ? x : y;
      hff_pkg::OP_CLPN: r = ($signed(x) > 0) ? '0 : x;
      hff_pkg::OP_CLPP: r = x[W-1] ? '0 : x;
      hff_pkg::OP_HALVE: begin
        // truncate toward zero
        m = mag(x) >> 1;
        r = x[W-1] ? (~m + 1'b1) : m;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  logic          busy;
  logic [3:0]    op_r;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [W-1:0]  ma;
  logic [P-1:0]  prod;
  logic [Q-1:0]  num;
  logic [W-1:0]  rem;
  logic [R-1:0]  sq_x;
  logic [H+1:0]  sq_rem;
  logic [H-1:0]  sq_root;

  logic [W+15:0] mul_pp;
  logic [W+15:0] mul_s;
  logic [W:0]    div_rs;
  logic [W:0]    div_diff;
  logic          div_ge;
  logic [H+1:0]  sq_rs;
  logic [H+1:0]  sq_trial;
  logic          sq_ge;

  always_comb begin
    mul_pp   = {16'b0, ma} * {{W{1'b0}}, prod[15:0]};
    mul_s    = {16'b0, prod[P-1:NB]} + mul_pp;
    div_rs   = {rem, num[Q-1]};
    div_diff = div_rs - {1'b0, ma};
    div_ge   = div_rs >= {1'b0, ma};
    sq_rs    = {sq_rem[H-1:0], sq_x[R-1:R-2]};
    sq_trial = {sq_root, 2'b01};
    sq_ge    = sq_rs >= sq_trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          case (op_r)
            hff_pkg::OP_MUL: res <= sat(neg, MX'(prod >> F));
            hff_pkg::OP_DIV: res <= sat(neg, MX'(num));
            default:         res <= sat(1'b0, MX'(sq_root));
          endcase
        end else begin
          done <= 1'b0;
          cnt  <= cnt - 1'b1;
          case (op_r)
            hff_pkg::OP_MUL: prod <= {mul_s, prod[NB-1:16]};
            hff_pkg::OP_DIV: begin
              rem <= div_ge ? div_diff[W-1:0] : div_rs[W-1:0];
              num <= {num[Q-2:0], div_ge};
            end
            default: begin
              sq_rem  <= sq_ge ? (sq_rs - sq_trial) : sq_rs;
              sq_root <= {sq_root[H-2:0], sq_ge};
              sq_x    <= {sq_x[R-3:0], 2'b00};
            end
          endcase
        end
      end else if (req.start) begin
        op_r <= req.op;
        case (req.op)
          hff_pkg::OP_MUL: begin
            done <= 1'b0;
            neg  <= a[W-1] ^ b[W-1];
            ma   <= mag(a);
            prod <= {{W{1'b0}}, NB'(mag(b))};
            cnt  <= CW'(NCH);
            busy <= 1'b1;
          end
          hff_pkg::OP_DIV: begin
            if (b == '0) begin
              res  <= '0;
              done <= 1'b1;
            end else begin
              done <= 1'b0;
              neg  <= a[W-1] ^ b[W-1];
              ma   <= mag(b);
              num  <= {mag(a), {F{1'b0}}};
              rem  <= '0;
              cnt  <= CW'(Q);
              busy <= 1'b1;
            end
          end
          hff_pkg::OP_SQRT: begin
            if (a[W-1] || a == '0) begin
              res  <= '0;
              done <= 1'b1;
            end else begin
              done    <= 1'b0;
              sq_x    <= R'({a, {F{1'b0}}});
              sq_rem  <= '0;
              sq_root <= '0;
              cnt     <= CW'(H);
              busy    <= 1'b1;
            end
          end
          default: begin
            res  <= simple(req.op, a, b);
            done <= 1'b1;
          end
        endcase
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

FILE: src/hff_front.sv
// Front end: accepts items, saturates fields to the word width and queues
// them (two entries) for the sequencer. Depends on hff_pkg.
module hff_front #(
  parameter int WORD_BITS = 64
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          in_valid,
  output logic                                          in_stall,
  input  hff_pkg::in_item_t                             in_item,
  output hff_pkg::head_t                                head,
  output logic [hff_pkg::NWORDS-1:0][WORD_BITS-1:0]     words,
  input  logic                                          pop
);

  localparam int W = WORD_BITS;

  function automatic logic [W-1:0] sat_in(input logic [63:0] v);
    logic [W-1:0] r;
    if ((&v[63:W-1]) || !(|v[63:W-1])) r = v[W-1:0];
    else if (v[63])                    r = {1'b1, {(W-1){1'b0}}};
    else                               r = {1'b0, {(W-1){1'b1}}};
    return r;
  endfunction

  logic [hff_pkg::NWORDS-1:0][W-1:0] in_words;
  logic [hff_pkg::NWORDS-1:0][W-1:0] slot_words [2];
  logic                              slot_func  [2];
  logic [1:0]                        count;
  logic                              wr_ptr;
  logic                              rd_ptr;
  logic                              push;

  always_comb begin
    in_words[hff_pkg::R_RL] = sat_in(in_item.density_left);
    in_words[hff_pkg::R_RR] = sat_in(in_item.density_right);
    in_words[hff_pkg::R_ML] = sat_in(in_item.momentum_left);
    in_words[hff_pkg::R_MR] = sat_in(in_item.momentum_right);
    in_words[hff_pkg::R_EL] = sat_in(in_item.energy_left);
    in_words[hff_pkg::R_ER] = sat_in(in_item.energy_right);
    in_words[hff_pkg::R_PL] = sat_in(in_item.pressure_left);
    in_words[hff_pkg::R_PR] = sat_in(in_item.pressure_right);
    in_words[hff_pkg::R_AL] = sat_in({1'b0, in_item.sound_left});
    in_words[hff_pkg::R_AR] = sat_in({1'b0, in_item.sound_right});
  end

  assign in_stall   = count == 2'd2;
  assign push       = in_valid && !in_stall;
  assign head.valid = count != 2'd0;
  assign head.func  = slot_func[rd_ptr];
  assign words      = slot_words[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        slot_words[wr_ptr] <= in_words;
        slot_func[wr_ptr]  <= in_item.func;
        wr_ptr             <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/hff_back.sv
// Back end: loads queued words into the register file and runs the flux
// program on the shared unit; holds the result beat. Depends on hff_pkg,
// hff_ram and hff_alu.
module hff_back #(
  parameter int WORD_BITS = 64,
  parameter int FRAC_BITS = 32
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  hff_pkg::head_t                            head,
  input  logic [hff_pkg::NWORDS-1:0][WORD_BITS-1:0] words,
  output logic                                      pop,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output hff_pkg::out_item_t                        out_item
);

  localparam int W = WORD_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]                state;
  logic [hff_pkg::PC_W-1:0]  pc;
  logic [3:0]                ld_idx;
  logic                      face_seen;
  logic                      is_face;
  logic                      degen;
  logic signed [W-1:0]       fm;
  logic signed [W-1:0]       fn;
  logic signed [W-1:0]       fe;
  logic signed [W-1:0]       fp;
  logic                      ovalid;

  hff_pkg::uop_t             uop;
  hff_pkg::alu_req_t         req;
  logic                      we;
  logic [hff_pkg::RF_AW-1:0] waddr;
  logic [W-1:0]              wdata;
  logic [W-1:0]              rda;
  logic [W-1:0]              rdb;
  logic                      alu_done;
  logic [W-1:0]              alu_res;
  logic                      ld_last;
  logic                      is_ctrl;
  logic                      emit;

  assign uop     = hff_pkg::rom(pc);
  assign ld_last = ld_idx == (is_face ? 4'(hff_pkg::NWORDS - 1) : 4'd1);
  assign is_ctrl = uop.op == hff_pkg::OP_JZ || uop.op == hff_pkg::OP_END;
  assign emit    = state == ST_EMIT && (!ovalid || !out_stall);

  assign req.start = state == ST_READ && !is_ctrl;
  assign req.op    = uop.op;

  assign we    = state == ST_LOAD || (state == ST_WAIT && alu_done);
  assign waddr = state == ST_LOAD ? hff_pkg::RF_AW'(ld_idx) : uop.dst;
  assign wdata = state == ST_LOAD ? words[ld_idx] : alu_res;

  // passive item before any face: no bounds are stored yet, so drop it as degenerate
  assign pop = (state == ST_LOAD && ld_last)
            || (state == ST_IDLE && head.valid && head.func == hff_pkg::FUNC_PASSIVE
                && !face_seen);

  assign out_valid = ovalid;

  hff_ram #(
    .WIDTH (W),
    .DEPTH (hff_pkg::RF_DEPTH)
  ) u_rf (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (uop.ra),
    .raddr_b (uop.rb),
    .rdata_a (rda),
    .rdata_b (rdb)
  );

  hff_alu #(
    .WORD_BITS (W),
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (rda),
    .b    (rdb),
    .done (alu_done),
    .res  (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      face_seen <= 1'b0;
      ovalid    <= 1'b0;
    end else begin
      if (emit) begin
        ovalid <= 1'b1;
      end else if (!out_stall) begin
        ovalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (head.valid) begin
            is_face <= head.func == hff_pkg::FUNC_FACE;
            ld_idx  <= 4'd0;
            fm      <= '0;
            fn      <= '0;
            fe      <= '0;
            fp      <= '0;
            degen   <= head.func == hff_pkg::FUNC_PASSIVE && !face_seen;
            if (head.func == hff_pkg::FUNC_PASSIVE && !face_seen) begin
              state <= ST_EMIT;
            end else begin
              state <= ST_LOAD;
            end
            if (head.func == hff_pkg::FUNC_FACE) begin
              face_seen <= 1'b1;
            end
          end
        end
        ST_LOAD: begin
          if (ld_last) begin
            pc    <= is_face ? hff_pkg::PC_FACE : hff_pkg::PC_PASSIVE;
            state <= ST_FETCH;
          end else begin
            ld_idx <= ld_idx + 4'd1;
          end
        end
        ST_FETCH: state <= ST_READ;
        ST_READ: begin
          if (uop.op == hff_pkg::OP_END) begin
            state <= ST_EMIT;
          end else if (uop.op == hff_pkg::OP_JZ) begin
            if (rda == '0) begin
              degen <= 1'b1;
              state <= ST_EMIT;
            end else begin
              pc    <= pc + 1'b1;
              state <= ST_FETCH;
            end
          end else begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (alu_done) begin
            case (uop.osel)
              hff_pkg::OS_MASS:    fm <= alu_res;
              hff_pkg::OS_MOM:     fn <= alu_res;
              hff_pkg::OS_ENERGY:  fe <= alu_res;
              hff_pkg::OS_PASSIVE: fp <= alu_res;
              default: ;
            endcase
            pc    <= pc + 1'b1;
            state <= ST_FETCH;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            out_item.flux_mass            <= 64'(fm);
            out_item.flux_normal_momentum <= 64'(fn);
            out_item.flux_energy          <= 64'(fe);
            out_item.flux_passive         <= 64'(fp);
            out_item.degenerate           <= degen;
            state                         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: src/hlle_face_flux.sv
// HLLE face flux top level: front queue plus sequenced back end.
// Depends on hff_pkg, hff_front and hff_back.
//
//   channel   handshake            payload               direction
//   item      item_valid/stall     hff_pkg::in_item_t    into block
//   result    result_valid/stall   hff_pkg::out_item_t   out of block
//
// One item at a time in the back end; the front queue holds two more.
// Processing time is set mostly by the one-bit-per-cycle divider (eight divides
// per face item, one per passive item), then by the three square roots of a face
// item and the 16-bit-chunk multiplier. A passive item before any face item skips
// the program and is emitted as degenerate.
// Synchronous reset clears the queue, sequencer and stored-face flag.
// The result register holds while result_stall is high; the queue keeps
// accepting until full.
module hlle_face_flux #(
  parameter int WORD_BITS = 64,
  parameter int FRAC_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  hff_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output hff_pkg::out_item_t result
);

  hff_pkg::head_t                            head;
  logic [hff_pkg::NWORDS-1:0][WORD_BITS-1:0] words;
  logic                                      pop;

  hff_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_valid),
    .in_stall (item_stall),
    .in_item  (item),
    .head     (head),
    .words    (words),
    .pop      (pop)
  );

  hff_back #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .words     (words),
    .pop       (pop),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_item  (result)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking bench for hlle_face_flux: face and passive beats are driven
// with random gaps, and each flux result is checked against an in-bench HLLE
// predictor in Q32.32. Depends on hff_pkg and the hlle_face_flux RTL.
`timescale 1ns / 100ps

module testbench;

  typedef logic signed [63:0] q_t;
  localparam q_t QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q_t QMIN = 64'sh8000_0000_0000_0000;
  localparam q_t QHALF = 64'sh0000_0000_8000_0000;
  localparam int ITEM_COUNT = 1000;
  localparam longint CYCLE_LIMIT = 6000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  hff_pkg::in_item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  hff_pkg::out_item_t result;

  hlle_face_flux uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always #5 clk = ~clk;

  // stored face state of the predictor
  q_t face_sl = 0, face_sr = 0, face_ul = 0, face_ur = 0;
  hff_pkg::out_item_t pending_flux[$];
  int errors = 0;
  int sent = 0;
  int burst_left = 0;
  longint cycles = 0;

  // ---------------- fixed-point predictor ----------------
  function automatic q_t clamp65(logic signed [64:0] s);
    if (s > $signed({1'b0, QMAX})) return QMAX;
    if (s < $signed({1'b1, QMIN})) return QMIN;
    return s[63:0];
  endfunction

  function automatic q_t qadd(q_t a, q_t b);
    return clamp65({a[63], a} + {b[63], b});
  endfunction

  function automatic q_t qsub(q_t a, q_t b);
    return clamp65({a[63], a} - {b[63], b});
  endfunction

  function automatic logic [63:0] qmag(q_t a);
    return a[63] ? 64'(-a) : a;
  endfunction

  function automatic q_t settle(bit neg, logic [127:0] m);
    if (neg) begin
      if (m > 128'h8000_0000_0000_0000) return QMIN;
      return -$signed(m[63:0]);
    end
    if (m > 128'h7FFF_FFFF_FFFF_FFFF) return QMAX;
    return m[63:0];
  endfunction

  function automatic q_t qmul(q_t a, q_t b);
    logic [127:0] p;
    p = {64'b0, qmag(a)} * {64'b0, qmag(b)};
    return settle(a[63] != b[63], p >> 32);
  endfunction

  function automatic q_t qdiv(q_t a, q_t b);
    logic [127:0] n;
    if (b == 0) return 0;
    n = {64'b0, qmag(a)} << 32;
    return settle(a[63] != b[63], n / {64'b0, qmag(b)});
  endfunction

  function automatic q_t qsqrt(q_t x);
    logic [127:0] xs, c;
    logic [63:0] root;
    if (x <= 0) return 0;
    xs = {64'b0, x} << 32;
    root = 0;
    for (int i = 63; i >= 0; i--) begin
      c = {64'b0, root | (64'd1 << i)};
      if (c * c <= xs) root = c[63:0];
    end
    return settle(1'b0, {64'b0, root});
  endfunction

  function automatic q_t hll_flux(q_t sl, q_t sr, q_t ds, q_t ql, q_t qr, q_t fl, q_t fr);
    q_t num;
    num = qsub(qmul(sr, fl), qmul(sl, fr));
    num = qadd(num, qmul(qmul(sl, sr), qsub(qr, ql)));
    return qdiv(num, ds);
  endfunction

  function automatic hff_pkg::out_item_t predict_flux(hff_pkg::in_item_t it);
    hff_pkg::out_item_t o;
    q_t rl, rr, ml, mr, el, er, pl, pr, al, ar;
    q_t sql, sqr, ul, ur, den, roeu, t1, du, w, roea, ha, sl, sr, ds, b1, b2;
    o = '0;
    rl = it.density_left;   rr = it.density_right;
    ml = it.momentum_left;  mr = it.momentum_right;
    el = it.energy_left;    er = it.energy_right;
    pl = it.pressure_left;  pr = it.pressure_right;
    al = {1'b0, it.sound_left};
    ar = {1'b0, it.sound_right};
    if (it.func == hff_pkg::FUNC_FACE) begin
      sql = qsqrt(rl);
      sqr = qsqrt(rr);
      ul = qdiv(ml, rl);
      ur = qdiv(mr, rr);
      den = qadd(sql, sqr);
      roeu = qdiv(qadd(qmul(sql, ul), qmul(sqr, ur)), den);
      t1 = qdiv(qadd(qmul(sql, qmul(al, al)), qmul(sqr, qmul(ar, ar))), den);
      du = qsub(ur, ul);
      w = qdiv(qmul(QHALF, qmul(sql, sqr)), qmul(den, den));
      roea = qsqrt(qadd(t1, qmul(qmul(w, du), du)));
      ha = qmul(QHALF, roea);
      b1 = qsub(ul, al);
      b2 = qsub(roeu, ha);
      sl = (b1 < b2) ? b1 : b2;
      b1 = qadd(roeu, ha);
      b2 = qadd(ur, ar);
      sr = (b1 > b2) ? b1 : b2;
      if (sl > 0) sl = 0;
      if (sr < 0) sr = 0;
      face_sl = sl; face_sr = sr; face_ul = ul; face_ur = ur;
      ds = qsub(sr, sl);
      o.degenerate = (ds == 0);
      if (ds != 0) begin
        o.flux_mass = hll_flux(sl, sr, ds, rl, rr, ml, mr);
        o.flux_normal_momentum = hll_flux(sl, sr, ds, ml, mr,
          qadd(qmul(ml, ul), pl), qadd(qmul(mr, ur), pr));
        o.flux_energy = hll_flux(sl, sr, ds, el, er,
          qmul(ul, qadd(el, pl)), qmul(ur, qadd(er, pr)));
      end
    end else begin
      ds = qsub(face_sr, face_sl);
      o.degenerate = (ds == 0);
      if (ds != 0)
        o.flux_passive = hll_flux(face_sl, face_sr, ds, rl, rr,
          qmul(face_ul, rl), qmul(face_ur, rr));
    end
    return o;
  endfunction

  // ---------------- stimulus helpers ----------------
  // moderate value: integer part up to span, random fraction, optional sign
  function automatic logic [63:0] moderate(int span, bit may_negate);
    logic [63:0] v;
    v = {32'd0, $urandom} + (64'($urandom_range(0, span)) << 32);
    if (may_negate && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic logic [63:0] wide_rand();
    return {$urandom, $urandom};
  endfunction

  function automatic hff_pkg::in_item_t face_beat(bit physical);
    hff_pkg::in_item_t it;
    if (physical) begin
      it.density_left = moderate(50, 1'b0);
      it.density_right = moderate(50, 1'b0);
      it.momentum_left = moderate(40, 1'b1);
      it.momentum_right = moderate(40, 1'b1);
      it.energy_left = moderate(500, 1'b0);
      it.energy_right = moderate(500, 1'b0);
      it.pressure_left = moderate(200, 1'b0);
      it.pressure_right = moderate(200, 1'b0);
      it.sound_left = 63'(moderate(30, 1'b0));
      it.sound_right = 63'(moderate(30, 1'b0));
    end else begin
      it.density_left = wide_rand();
      it.density_right = wide_rand();
      it.momentum_left = wide_rand();
      it.momentum_right = wide_rand();
      it.energy_left = wide_rand();
      it.energy_right = wide_rand();
      it.pressure_left = wide_rand();
      it.pressure_right = wide_rand();
      it.sound_left = 63'(wide_rand());
      it.sound_right = 63'(wide_rand());
    end
    it.func = hff_pkg::FUNC_FACE;
    return it;
  endfunction

  function automatic hff_pkg::in_item_t passive_beat(bit physical);
    hff_pkg::in_item_t it;
    it = face_beat(1'b0);  // unused fields carry noise
    it.func = hff_pkg::FUNC_PASSIVE;
    if (physical) begin
      it.density_left = moderate(100, 1'b1);
      it.density_right = moderate(100, 1'b1);
    end
    return it;
  endfunction

  // drive one beat; valid stays high across back-to-back beats
  task automatic send_item(hff_pkg::in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_flux.push_back(predict_flux(it));
    sent++;
  endtask

  // ---------------- tests ----------------
  task automatic test_passive_before_face();
    send_item(passive_beat(1'b1));
    send_item(passive_beat(1'b0));
  endtask

  task automatic test_zero_spread();
    hff_pkg::in_item_t it;
    it = '0;
    it.func = hff_pkg::FUNC_FACE;
    send_item(it);           // all zero: bounds collapse to zero
    send_item(passive_beat(1'b1));
  endtask

  task automatic test_field_extremes();
    hff_pkg::in_item_t it;
    it = '1;
    it.func = hff_pkg::FUNC_FACE;
    send_item(it);
    it = '0;
    it.func = hff_pkg::FUNC_FACE;
    it.density_left = QMAX; it.density_right = QMAX;
    it.momentum_left = QMIN; it.momentum_right = QMAX;
    it.energy_left = QMAX; it.energy_right = QMIN;
    it.pressure_left = QMIN; it.pressure_right = QMAX;
    it.sound_left = '1; it.sound_right = '1;
    send_item(it);
    it.func = hff_pkg::FUNC_PASSIVE;
    it.density_left = QMIN; it.density_right = QMAX;
    send_item(it);
    it.density_left = QMAX; it.density_right = QMIN;
    send_item(it);
    // zero densities with momentum: divide by zero gives zero velocity
    it = face_beat(1'b1);
    it.density_left = 0; it.density_right = 0;
    send_item(it);
    send_item(passive_beat(1'b1));
    // negative densities: roots of negatives are zero
    it = face_beat(1'b1);
    it.density_left = QMIN; it.density_right = -64'sd1;
    send_item(it);
    send_item(passive_beat(1'b1));
    // min density magnitudes, a maximal left and a zero right sound speed
    it = face_beat(1'b1);
    it.density_left = 64'sd1; it.density_right = 64'sd1;
    it.sound_left = '1; it.sound_right = 63'd0;
    send_item(it);
    send_item(passive_beat(1'b0));
  endtask

  task automatic test_physical_faces();
    for (int i = 0; i < 6; i++) begin
      send_item(face_beat(1'b1));
      send_item(passive_beat(1'b1));
    end
  endtask

  task automatic test_random_sequences();
    while (sent < ITEM_COUNT) begin
      send_item(face_beat($urandom_range(0, 4) != 0));
      repeat ($urandom_range(0, 4))
        send_item(passive_beat($urandom_range(0, 4) != 0));
      if ($urandom_range(0, 15) == 0)
        send_item(passive_beat(1'b0));
    end
  endtask

  // ---------------- result side ----------------
  int stall_left = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(20, 300);
      stall_mode = $urandom_range(0, 2);
    end
    stall_left--;
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 3) == 0);
      default: result_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  task automatic flag_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    hff_pkg::out_item_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (pending_flux.size() == 0) begin
        $display("%0t unexpected result beat: expected none actual %h", $time, result);
        errors++;
      end else begin
        exp_r = pending_flux.pop_front();
        flag_field("flux_mass", exp_r.flux_mass, result.flux_mass);
        flag_field("flux_normal_momentum", exp_r.flux_normal_momentum,
                   result.flux_normal_momentum);
        flag_field("flux_energy", exp_r.flux_energy, result.flux_energy);
        flag_field("flux_passive", exp_r.flux_passive, result.flux_passive);
        flag_field("degenerate", 64'(exp_r.degenerate), 64'(result.degenerate));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_passive_before_face();
    test_zero_spread();
    test_field_extremes();
    test_physical_faces();
    test_random_sequences();
    item_valid <= 1'b0;
    while (pending_flux.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_flux.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
src/hff_pkg.sv
src/hff_ram.sv
src/hff_alu.sv
src/hff_front.sv
src/hff_back.sv
src/hlle_face_flux.sv
tb/testbench.sv
